>>> rtl/core/u8hn_pkg.sv
// Shared types, constants and decode functions of the UTF-8 homoglyph normalizer.
package u8hn_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

    localparam int CP_WIDTH = 21;

    // Zero-width code points.
    localparam logic [CP_WIDTH-1:0] CpZwsp = 21'h0200B;
    localparam logic [CP_WIDTH-1:0] CpZwnj = 21'h0200C;
    localparam logic [CP_WIDTH-1:0] CpZwj  = 21'h0200D;
    localparam logic [CP_WIDTH-1:0] CpWj   = 21'h02060;
    localparam logic [CP_WIDTH-1:0] CpBom  = 21'h0FEFF;
    localparam logic [CP_WIDTH-1:0] CpShy  = 21'h000AD;

    typedef struct packed {
        logic load;     // take the input beat into the pending buffer
        logic step;     // one decode or emit step on the buffer head
        logic summary;  // load the end-of-text summary into the output register
    } t_ctl_cmd;

    typedef struct packed {
        logic completes; // the offered byte closes a sequence or the text
        logic done;      // nothing left in the buffer
        logic step_ok;   // a step can proceed this cycle
        logic out_free;  // output register can take a beat
        logic text_end;  // the buffered sequence ends the text
    } t_dp_status;

    typedef struct packed {
        logic       hit;
        logic [7:0] ch;
    } t_glyph;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        if (b[7] == 1'b0)             len = 3'd1;
        else if (b[7:5] == 3'b110)    len = 3'd2;
        else if (b[7:4] == 4'b1110)   len = 3'd3;
        else if (b[7:3] == 5'b11110)  len = 3'd4;
        else                          len = 3'd1;
        return len;
    endfunction

    function automatic logic is_zero_width(input logic [CP_WIDTH-1:0] cp);
        return (cp == CpZwsp) || (cp == CpZwnj) || (cp == CpZwj) ||
               (cp == CpWj) || (cp == CpBom) || (cp == CpShy);
    endfunction

    function automatic t_glyph glyph_map(input logic [CP_WIDTH-1:0] cp);
        t_glyph g;
        g.hit = 1'b1;
        case (cp) inside
            21'h00430, 21'h00410, 21'h003B1:            g.ch = 8'h61; // a
            21'h00435, 21'h00415:                       g.ch = 8'h65; // e
            21'h0043E, 21'h0041E, 21'h003BF:            g.ch = 8'h6F; // o
            21'h00440, 21'h00420, 21'h003C1:            g.ch = 8'h70; // p
            21'h00441, 21'h00421:                       g.ch = 8'h63; // c
            21'h00443, 21'h003C5:                       g.ch = 8'h79; // y
            21'h00445, 21'h00425, 21'h003C7:            g.ch = 8'h78; // x
            21'h00456, 21'h00406:                       g.ch = 8'h69; // i
            21'h00455, 21'h00405:                       g.ch = 8'h73; // s
            21'h00412:                                  g.ch = 8'h62; // b
            21'h0041D:                                  g.ch = 8'h68; // h
            21'h0041C:                                  g.ch = 8'h6D; // m
            21'h00422:                                  g.ch = 8'h74; // t
            21'h0041A, 21'h003BA:                       g.ch = 8'h6B; // k
            21'h003BD:                                  g.ch = 8'h76; // v
            default: begin
                g.hit = 1'b0;
                g.ch  = 8'h00;
            end
        endcase
        return g;
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c, input logic en);
        logic [7:0] r;
        if (en && c >= 8'h41 && c <= 8'h5A) r = c + 8'h20;
        else                                 r = c;
        return r;
    endfunction

endpackage

>>> rtl/core/u8hn_in_if.sv
// Input byte channel: valid/ready handshake with the raw byte and end-of-text flag.
interface u8hn_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       text_end;

    modport source (output valid, output data_byte, output text_end, input ready);
    modport sink   (input valid, input data_byte, input text_end, output ready);
endinterface

>>> rtl/core/u8hn_out_if.sv
// Result channel: valid/ready handshake with a normalized byte or a summary.
interface u8hn_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        is_summary;
    logic [15:0] zero_width_count;
    logic [15:0] homoglyph_count;
    logic        obfuscation_found;

    modport source (output valid, output out_byte, output is_summary,
                    output zero_width_count, output homoglyph_count,
                    output obfuscation_found, input ready);
    modport sink   (input valid, input out_byte, input is_summary,
                    input zero_width_count, input homoglyph_count,
                    input obfuscation_found, output ready);
endinterface

>>> rtl/core/u8hn_cfg_if.sv
// Configuration write channel carrying the lowercase enable bit.
interface u8hn_cfg_if;
    logic valid;
    logic ready;
    logic lowercase_enable;

    modport source (output valid, output lowercase_enable, input ready);
    modport sink   (input valid, input lowercase_enable, output ready);
endinterface

>>> rtl/core/u8hn_ctrl.sv
// Controller state machine: byte intake, decode steps and summary issue.
module u8hn_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  u8hn_pkg::t_dp_status i_status,
    output logic                o_in_ready,
    output u8hn_pkg::t_ctl_cmd  o_cmd
);
    import u8hn_pkg::*;

    localparam logic [1:0] S_IN   = 2'd0;
    localparam logic [1:0] S_WORK = 2'd1;
    localparam logic [1:0] S_SUM  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IN: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_status.completes) n_state = S_WORK;
                end
            end
            S_WORK: begin
                if (i_status.done) begin
                    n_state = i_status.text_end ? S_SUM : S_IN;
                end else if (i_status.step_ok) begin
                    o_cmd.step = 1'b1;
                end
            end
            S_SUM: begin
                if (i_status.out_free) begin
                    o_cmd.summary = 1'b1;
                    n_state       = S_IN;
                end
            end
            default: n_state = S_IN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IN;
        else          r_state <= n_state;
    end

endmodule

>>> rtl/core/u8hn_dp.sv
// Datapath: pending byte buffer, code point decode, counters and output register.
module u8hn_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  u8hn_pkg::t_ctl_cmd          i_cmd,
    output u8hn_pkg::t_dp_status        o_status,
    input  logic [7:0]                  i_data_byte,
    input  logic                        i_text_end,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_lowercase,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output logic [7:0]                  o_out_byte,
    output logic                        o_out_summary,
    output logic [15:0]                 o_out_zw,
    output logic [15:0]                 o_out_hg,
    output logic                        o_out_obf
);
    import u8hn_pkg::*;

    logic [7:0]             r_buf [4];
    logic [7:0]             n_buf [4];
    logic [2:0]             r_cnt, n_cnt;
    logic [2:0]             r_exp, n_exp;
    logic [1:0]             r_run, n_run;
    logic                   r_end, n_end;
    logic                   r_lc;
    logic [COUNT_WIDTH-1:0] r_zw, n_zw;
    logic [COUNT_WIDTH-1:0] r_hg, n_hg;
    logic                   r_obf, n_obf;

    logic                   r_ov;
    logic [7:0]             r_ob;
    logic                   r_os;
    logic [15:0]            r_ozw, r_ohg;
    logic                   r_oobf;

    logic [CP_WIDTH-1:0]    cp;
    logic [2:0]             used;
    logic                   zw_hit;
    t_glyph                 glyph;
    logic                   out_free;
    logic                   needs_emit;
    logic [7:0]             emit_byte;
    logic [2:0]             shift;
    logic [2:0]             exp_eff;
    logic [2:0]             cnt_inc;
    logic [2:0]             src;

    // Decode the code point that starts at the buffer head.
    always_comb begin
        cp   = {13'd0, r_buf[0]};
        used = 3'd1;
        if (r_buf[0][7:5] == 3'b110 && r_cnt >= 3'd2) begin
            cp   = {10'd0, r_buf[0][4:0], r_buf[1][5:0]};
            used = 3'd2;
        end else if (r_buf[0][7:4] == 4'b1110 && r_cnt >= 3'd3) begin
            cp   = {5'd0, r_buf[0][3:0], r_buf[1][5:0], r_buf[2][5:0]};
            used = 3'd3;
        end else if (r_buf[0][7:3] == 5'b11110 && r_cnt >= 3'd4) begin
            cp   = {r_buf[0][2:0], r_buf[1][5:0], r_buf[2][5:0], r_buf[3][5:0]};
            used = 3'd4;
        end
        zw_hit = is_zero_width(cp);
        glyph  = glyph_map(cp);
    end

    assign out_free   = !r_ov || i_out_ready;
    assign needs_emit = (r_run != 2'd0) || !zw_hit;
    assign cnt_inc    = r_cnt + 3'd1;
    assign exp_eff    = (r_cnt == 3'd0) ? lead_len(i_data_byte) : r_exp;

    assign o_status.completes = (cnt_inc >= exp_eff) || i_text_end;
    assign o_status.done      = (r_cnt == 3'd0);
    assign o_status.step_ok   = out_free || !needs_emit;
    assign o_status.out_free  = out_free;
    assign o_status.text_end  = r_end;

    always_comb begin
        n_buf = r_buf;
        n_cnt = r_cnt;
        n_exp = r_exp;
        n_run = r_run;
        n_end = r_end;
        n_zw  = r_zw;
        n_hg  = r_hg;
        n_obf = r_obf;
        emit_byte = r_buf[0];
        shift = 3'd0;
        src   = 3'd0;

        if (i_cmd.load) begin
            n_buf[r_cnt[1:0]] = i_data_byte;
            n_cnt = cnt_inc;
            n_end = i_text_end;
            if (r_cnt == 3'd0) n_exp = lead_len(i_data_byte);
        end

        if (i_cmd.step) begin
            if (r_run != 2'd0) begin
                // Remaining bytes of a sequence that passes through untouched.
                emit_byte = r_buf[0];
                shift     = 3'd1;
                n_run     = r_run - 2'd1;
            end else if (zw_hit) begin
                shift = used;
                if (r_zw != CountMax) n_zw = r_zw + 1'b1;
                n_obf = 1'b1;
            end else if (glyph.hit) begin
                emit_byte = fold(glyph.ch, r_lc);
                shift     = used;
                if (r_hg != CountMax) n_hg = r_hg + 1'b1;
                n_obf = 1'b1;
            end else if (used == 3'd1) begin
                emit_byte = fold(r_buf[0], r_lc);
                shift     = 3'd1;
            end else begin
                emit_byte = r_buf[0];
                shift     = 3'd1;
                n_run     = 2'(used - 3'd1);
            end
            n_cnt = r_cnt - shift;
            for (int k = 0; k < 4; k++) begin
                src = 3'(k) + shift;
                if (src < 3'd4) n_buf[k] = r_buf[src[1:0]];
            end
        end

        if (i_cmd.summary) begin
            n_zw  = '0;
            n_hg  = '0;
            n_obf = 1'b0;
            n_end = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_exp <= '0;
            r_run <= '0;
            r_end <= 1'b0;
            r_zw  <= '0;
            r_hg  <= '0;
            r_obf <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_exp <= n_exp;
            r_run <= n_run;
            r_end <= n_end;
            r_zw  <= n_zw;
            r_hg  <= n_hg;
            r_obf <= n_obf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lc <= 1'b0;
        end else if (i_cfg_valid) begin
            r_lc <= i_cfg_lowercase;
        end
    end

    // Output register; a beat is loaded only when the slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.summary) begin
            r_ov <= 1'b1;
        end else if (i_cmd.step && needs_emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.summary) begin
            r_ob   <= 8'h00;
            r_os   <= 1'b1;
            r_ozw  <= 16'(r_zw);
            r_ohg  <= 16'(r_hg);
            r_oobf <= r_obf;
        end else if (i_cmd.step && needs_emit) begin
            r_ob   <= emit_byte;
            r_os   <= 1'b0;
            r_ozw  <= 16'd0;
            r_ohg  <= 16'd0;
            r_oobf <= 1'b0;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_out_byte    = r_ob;
    assign o_out_summary = r_os;
    assign o_out_zw      = r_ozw;
    assign o_out_hg      = r_ohg;
    assign o_out_obf     = r_oobf;

endmodule

>>> rtl/core/utf8_homoglyph_zero_width_normalizer.sv
// Flow: the byte that completes a code point is accepted, then the buffer is worked off
// in decode steps; each emitted byte shows in the output register the cycle after its step.
// Intake: the bytes of a sequence are taken one by one, and no new byte is accepted until
// the buffer is worked off, one step per emitted byte (one for a dropped or replaced code
// point); end of text adds a summary beat. Output back-pressure stalls steps.
// Reset (synchronous, active low) clears the buffer count, counters and config bit.
module utf8_homoglyph_zero_width_normalizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u8hn_in_if.sink     i_in,
    u8hn_out_if.source  o_out,
    u8hn_cfg_if.sink    i_cfg
);
    import u8hn_pkg::*;

    t_ctl_cmd   cmd;
    t_dp_status st;
    logic       in_ready;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    u8hn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (st),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    u8hn_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (st),
        .i_data_byte     (i_in.data_byte),
        .i_text_end      (i_in.text_end),
        .i_cfg_valid     (i_cfg.valid),
        .i_cfg_lowercase (i_cfg.lowercase_enable),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_out_byte      (o_out.out_byte),
        .o_out_summary   (o_out.is_summary),
        .o_out_zw        (o_out.zero_width_count),
        .o_out_hg        (o_out.homoglyph_count),
        .o_out_obf       (o_out.obfuscation_found)
    );

    // Intake and buffer work never share a cycle.
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.load && (cmd.step || cmd.summary)))
        else $error("load issued together with a step or summary");

    // A summary command shows up as a summary beat in the next cycle.
    a_summary_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.summary |=> (o_out.valid && o_out.is_summary))
        else $error("summary beat missing after summary command");

    // A byte that closes a sequence stops intake until the buffer is worked off.
    a_intake_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && st.completes) |=> !i_in.ready)
        else $error("input still ready after a completing byte");

    // A step that emits a byte only happens when the output slot is free.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> $stable(o_out.out_byte))
        else $error("pending output beat overwritten");

endmodule

>>> dv/u8hn_norm_checker.sv
`timescale 1ns / 1ps
// Result checker for the UTF-8 normalizer: predicts the output beats of each text and compares them.
module u8hn_norm_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    u8hn_in_if   i_in,
    u8hn_out_if  i_out,
    u8hn_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_outstanding,
    output int   o_checked
);
    import u8hn_pkg::*;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_summary;
        logic [15:0] zero_width_count;
        logic [15:0] homoglyph_count;
        logic        obfuscation_found;
    } t_norm_beat;

    t_norm_beat             awaited_norm_beats[$];
    logic                   lower_en;
    logic [7:0]             held_bytes [3];
    int                     held_count;
    int                     want_len;
    logic [7:0]             seq_buf [4];
    logic [COUNT_WIDTH-1:0] zw_total;
    logic [COUNT_WIDTH-1:0] hg_total;
    logic                   obf_seen;
    int                     fails;
    int                     checked;

    function automatic int seq_length(input logic [7:0] b);
        if (!b[7]) return 1;
        if (b[7:5] == 3'b110) return 2;
        if (b[7:4] == 4'b1110) return 3;
        if (b[7:3] == 5'b11110) return 4;
        return 1;
    endfunction

    function automatic logic is_invisible(input logic [20:0] cp);
        case (cp)
            21'h0200B, 21'h0200C, 21'h0200D, 21'h02060, 21'h0FEFF, 21'h000AD: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // Returns the ASCII letter a lookalike stands for, or zero when it is not one.
    function automatic logic [7:0] ascii_lookalike(input logic [20:0] cp);
        case (cp)
            21'h00430, 21'h00410, 21'h003B1: return "a";
            21'h00435, 21'h00415:            return "e";
            21'h0043E, 21'h0041E, 21'h003BF: return "o";
            21'h00440, 21'h00420, 21'h003C1: return "p";
            21'h00441, 21'h00421:            return "c";
            21'h00443, 21'h003C5:            return "y";
            21'h00445, 21'h00425, 21'h003C7: return "x";
            21'h00456, 21'h00406:            return "i";
            21'h00455, 21'h00405:            return "s";
            21'h00412:                       return "b";
            21'h0041D:                       return "h";
            21'h0041C:                       return "m";
            21'h00422:                       return "t";
            21'h0041A, 21'h003BA:            return "k";
            21'h003BD:                       return "v";
            default:                         return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (lower_en && c >= "A" && c <= "Z") return c + 8'd32;
        return c;
    endfunction

    task automatic push_data(input logic [7:0] b);
        t_norm_beat r;
        r = '0;
        r.out_byte = b;
        awaited_norm_beats = {awaited_norm_beats, r};
    endtask

    // Walks the gathered bytes; a lead whose sequence does not fit stands alone.
    task automatic decode_held(input int n);
        int         i;
        int         used;
        logic [7:0] lead;
        logic [7:0] glyph;
        logic [20:0] cp;
        i = 0;
        while (i < n) begin
            lead = seq_buf[i];
            used = 1;
            cp = {13'd0, lead};
            if (lead[7:5] == 3'b110 && i + 1 < n) begin
                used = 2;
                cp = {10'd0, lead[4:0], seq_buf[i+1][5:0]};
            end else if (lead[7:4] == 4'b1110 && i + 2 < n) begin
                used = 3;
                cp = {5'd0, lead[3:0], seq_buf[i+1][5:0], seq_buf[i+2][5:0]};
            end else if (lead[7:3] == 5'b11110 && i + 3 < n) begin
                used = 4;
                cp = {lead[2:0], seq_buf[i+1][5:0], seq_buf[i+2][5:0], seq_buf[i+3][5:0]};
            end
            glyph = ascii_lookalike(cp);
            if (is_invisible(cp)) begin
                if (zw_total != '1) zw_total++;
                obf_seen = 1'b1;
            end else if (glyph != 8'h00) begin
                push_data(fold_case(glyph));
                if (hg_total != '1) hg_total++;
                obf_seen = 1'b1;
            end else if (used == 1) begin
                push_data(fold_case(lead));
            end else begin
                for (int k = 0; k < used; k++) push_data(seq_buf[i+k]);
            end
            i += used;
        end
    endtask

    task automatic normalize_byte(input logic [7:0] b, input logic last);
        int         n;
        t_norm_beat summ;
        for (int k = 0; k < held_count; k++) seq_buf[k] = held_bytes[k];
        seq_buf[held_count] = b;
        n = held_count + 1;
        if (held_count == 0) want_len = seq_length(b);
        if (n >= want_len || last) begin
            decode_held(n);
            held_count = 0;
            want_len = 0;
        end else begin
            held_bytes[held_count] = b;
            held_count = n;
        end
        if (last) begin
            summ = '0;
            summ.is_summary = 1'b1;
            summ.zero_width_count = zw_total;
            summ.homoglyph_count = hg_total;
            summ.obfuscation_found = obf_seen;
            awaited_norm_beats = {awaited_norm_beats, summ};
            zw_total = '0;
            hg_total = '0;
            obf_seen = 1'b0;
        end
    endtask

    task automatic compare_field(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            fails++;
            $display("t=%0t: %s mismatch, expected 0x%h, actual 0x%h",
                     $time, what, want, got);
        end
    endtask

    task automatic check_beat();
        t_norm_beat want;
        t_norm_beat got;
        got.out_byte = i_out.out_byte;
        got.is_summary = i_out.is_summary;
        got.zero_width_count = i_out.zero_width_count;
        got.homoglyph_count = i_out.homoglyph_count;
        got.obfuscation_found = i_out.obfuscation_found;
        checked++;
        if (awaited_norm_beats.size() == 0) begin
            fails++;
            $display("t=%0t: unexpected output beat, expected none, actual 0x%h",
                     $time, got);
        end else begin
            want = awaited_norm_beats.pop_front();
            compare_field("out_byte", 16'(want.out_byte), 16'(got.out_byte));
            compare_field("is_summary", 16'(want.is_summary), 16'(got.is_summary));
            compare_field("zero_width_count", want.zero_width_count, got.zero_width_count);
            compare_field("homoglyph_count", want.homoglyph_count, got.homoglyph_count);
            compare_field("obfuscation_found", 16'(want.obfuscation_found),
                          16'(got.obfuscation_found));
        end
    endtask

    initial begin
        fails = 0;
        checked = 0;
    end

    // Outputs are compared before the input of the same edge is absorbed, since a
    // byte cannot produce a beat on the edge it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            awaited_norm_beats.delete();
            lower_en = 1'b0;
            held_count = 0;
            want_len = 0;
            zw_total = '0;
            hg_total = '0;
            obf_seen = 1'b0;
        end else begin
            if (i_out.valid && i_out.ready) check_beat();
            if (i_in.valid && i_in.ready) normalize_byte(i_in.data_byte, i_in.text_end);
            if (i_cfg.valid && i_cfg.ready) lower_en = i_cfg.lowercase_enable;
        end
        o_fail_count <= fails;
        o_outstanding <= awaited_norm_beats.size();
        o_checked <= checked;
    end

endmodule

>>> dv/utf8_homoglyph_zero_width_normalizer_tb.sv
`timescale 1ns / 1ps
// Top of the normalizer regression: clock, reset, text stimulus, output pacing and verdict.
module utf8_homoglyph_zero_width_normalizer_tb;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_BYTES  = 300;
    localparam int CALM_BYTES    = 40;

    logic i_clk;
    logic i_rst_n;
    logic calm = 1'b0;
    int   cycle_count = 0;
    int   bytes_sent = 0;
    int   texts_sent = 0;
    int   fail_count;
    int   outstanding;
    int   checked;
    logic [7:0] text_q[$];

    logic [20:0] lookalike_cps [29] = '{
        21'h00430, 21'h00435, 21'h0043E, 21'h00440, 21'h00441, 21'h00443, 21'h00445,
        21'h00456, 21'h00455, 21'h00410, 21'h00415, 21'h0041E, 21'h00420, 21'h00421,
        21'h00425, 21'h00406, 21'h00405, 21'h00412, 21'h0041D, 21'h0041C, 21'h00422,
        21'h0041A, 21'h003B1, 21'h003BF, 21'h003C5, 21'h003C1, 21'h003BA, 21'h003BD,
        21'h003C7
    };
    logic [20:0] invisible_cps [6] = '{
        21'h0200B, 21'h0200C, 21'h0200D, 21'h02060, 21'h0FEFF, 21'h000AD
    };

    u8hn_in_if  in_ch ();
    u8hn_out_if out_ch ();
    u8hn_cfg_if cfg_ch ();

    utf8_homoglyph_zero_width_normalizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    u8hn_norm_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .i_cfg         (cfg_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("utf8_homoglyph_zero_width_normalizer regression: fail");
            $finish;
        end
    end

    // Output back-pressure: stall bursts between runs of ready, none once calm.
    initial begin : sink_pacing
        int n;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                n = $urandom_range(1, 11);
            end else begin
                out_ch.ready <= 1'b1;
                n = $urandom_range(1, 24);
            end
            repeat (n) @(posedge i_clk);
        end
    end

    function automatic logic [7:0] lead_of(input int len);
        case (len)
            2:       return {3'b110, 5'($urandom)};
            3:       return {4'b1110, 4'($urandom)};
            default: return {5'b11110, 3'($urandom)};
        endcase
    endfunction

    // Continuation bytes are not validated, so a few carry arbitrary top bits.
    function automatic logic [7:0] cont_byte();
        if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    task automatic add_byte(input logic [7:0] b);
        text_q = {text_q, b};
    endtask

    task automatic add_code_point(input logic [20:0] cp);
        if (cp < 21'h80) begin
            add_byte(cp[7:0]);
        end else if (cp < 21'h800) begin
            add_byte({3'b110, cp[10:6]});
            add_byte({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            add_byte({4'b1110, cp[15:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
        end else begin
            add_byte({5'b11110, cp[20:18]});
            add_byte({2'b10, cp[17:12]});
            add_byte({2'b10, cp[11:6]});
            add_byte({2'b10, cp[5:0]});
        end
    endtask

    task automatic add_random_unit();
        int          kind;
        int          len;
        logic [20:0] cp;
        kind = $urandom_range(0, 15);
        if (kind <= 1 || kind >= 14) begin
            add_byte(8'h41 + 8'($urandom_range(0, 25))
                     + ($urandom_range(0, 1) ? 8'h20 : 8'h00));
        end else if (kind == 2) begin
            add_byte(8'($urandom_range(0, 127)));
        end else if (kind <= 5) begin
            add_code_point(lookalike_cps[$urandom_range(0, 28)]);
        end else if (kind <= 7) begin
            cp = invisible_cps[$urandom_range(0, 5)];
            if (cp == 21'h000AD && $urandom_range(0, 1)) begin
                // Soft hyphen as a lone byte or as a three-byte overlong form.
                if ($urandom_range(0, 1)) add_byte(8'hAD);
                else text_q = {text_q, 8'hE0, 8'h82, 8'hAD};
            end else begin
                add_code_point(cp);
            end
        end else if (kind <= 9) begin
            len = $urandom_range(2, 4);
            add_byte(lead_of(len));
            repeat (len - 1) add_byte(cont_byte());
        end else if (kind <= 11) begin
            add_byte(8'($urandom_range(0, 255)));
        end else if (kind == 12) begin
            add_byte($urandom_range(0, 1) ? 8'($urandom_range(8'hF8, 8'hFF))
                                          : 8'($urandom_range(8'h80, 8'hBF)));
        end else begin
            // A sequence cut short; the following bytes are taken as its continuation.
            len = $urandom_range(2, 4);
            add_byte(lead_of(len));
            repeat ($urandom_range(0, len - 2)) add_byte(cont_byte());
        end
    endtask

    task automatic build_random_text();
        int len;
        repeat ($urandom_range(1, 8)) add_random_unit();
        if ($urandom_range(0, 3) == 0) begin
            len = $urandom_range(2, 4);
            add_byte(lead_of(len));
            repeat ($urandom_range(0, len - 2)) add_byte(cont_byte());
        end
    endtask

    task automatic send_beat(input logic [7:0] b, input logic last);
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.text_end <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        bytes_sent++;
    endtask

    task automatic send_text();
        foreach (text_q[k]) send_beat(text_q[k], k == text_q.size() - 1);
        texts_sent++;
        text_q.delete();
    endtask

    // The count from the checker is registered, hence the wait for an edge before looking.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_lowercase(input logic en);
        cfg_ch.valid <= 1'b1;
        cfg_ch.lowercase_enable <= en;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin : stimulus
        int target;
        in_ch.valid <= 1'b0;
        in_ch.data_byte <= 8'h00;
        in_ch.text_end <= 1'b0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.lowercase_enable <= 1'b0;
        i_rst_n <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Field extremes and stray bytes; the lone 0xAD at the end is dropped.
        text_q = '{8'h41, 8'h00, 8'hFF, 8'h80, 8'hAD};
        send_text();
        // Lookalikes, a zero-width space, an overlong soft hyphen and a 4-byte pass-through.
        text_q = '{8'hD0, 8'hB0, 8'hCE, 8'hB1, 8'hE2, 8'h80, 8'h8B,
                   8'hE0, 8'h82, 8'hAD, 8'hF0, 8'h9F, 8'h98, 8'h80};
        send_text();
        // Text ends inside a sequence: both bytes come out on their own.
        text_q = '{8'hE2, 8'h80};
        send_text();
        // The 4-byte lead cannot fit, but the two bytes after it form a lookalike.
        text_q = '{8'hF0, 8'hD0, 8'hB0};
        send_text();
        wait_drained();

        write_lowercase(1'b1);
        text_q = '{8'h5A, 8'h40, 8'h5B, 8'h41};
        send_text();
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            write_lowercase(phase[0]);
            target = bytes_sent + RANDOM_BYTES / 4;
            while (bytes_sent < target) begin
                build_random_text();
                send_text();
            end
            wait_drained();
        end

        calm = 1'b1;
        target = bytes_sent + CALM_BYTES;
        while (bytes_sent < target) begin
            build_random_text();
            send_text();
        end
        wait_drained();

        $display("Sent %0d texts in %0d bytes and checked %0d output beats.",
                 texts_sent, bytes_sent, checked);
        $display("Covered both case settings, cut-short tails, stray and overlong bytes,"
                 , " and back-pressure on both channels.");
        if (fail_count == 0 && outstanding == 0) begin
            $display("utf8_homoglyph_zero_width_normalizer regression: pass");
        end else begin
            $display("utf8_homoglyph_zero_width_normalizer regression: fail");
        end
        $finish;
    end

endmodule

>>> utf8_homoglyph_zero_width_normalizer.f
rtl/core/u8hn_pkg.sv
rtl/core/u8hn_in_if.sv
rtl/core/u8hn_out_if.sv
rtl/core/u8hn_cfg_if.sv
rtl/core/u8hn_ctrl.sv
rtl/core/u8hn_dp.sv
rtl/core/utf8_homoglyph_zero_width_normalizer.sv
dv/u8hn_norm_checker.sv
dv/utf8_homoglyph_zero_width_normalizer_tb.sv
